>>> sv/bmv_pkg.sv
// ----------------------------------------------------------------------------
// bmv_pkg
// Shared types, widths and the face table of the box mesh vertex generator.
// ----------------------------------------------------------------------------
package bmv_pkg;

  localparam int SEG_W     = 8;
  localparam int DIM_W     = 16;
  localparam int NUM_W     = 24;
  localparam int QUO_W     = 16;
  localparam int IDX_W     = 19;
  localparam int STR_W     = 9;
  localparam int POS_W     = 17;
  localparam int AREA_W    = 17;
  localparam int TEX_W     = 16;
  localparam int NRM_W     = 2;
  localparam int FACE_W    = 3;
  localparam int CIDX_W    = 3;
  localparam int LANES     = 4;
  localparam int NUM_FACES = 6;
  localparam int UV_SHIFT  = 15;

  localparam logic [TEX_W-1:0]        UV_ONE  = 16'h8000;
  localparam logic signed [NRM_W-1:0] NRM_POS = 2'sb01;
  localparam logic signed [NRM_W-1:0] NRM_NEG = 2'sb11;
  localparam logic signed [NRM_W-1:0] NRM_ZERO = 2'sb00;

  typedef enum logic [CIDX_W-1:0] {
    REG_BOX_WIDTH,
    REG_BOX_HEIGHT,
    REG_BOX_DEPTH,
    REG_WIDTH_SEG,
    REG_HEIGHT_SEG,
    REG_DEPTH_SEG
  } reg_idx_t;

  typedef enum logic [FACE_W-1:0] {
    FACE_PX,
    FACE_NX,
    FACE_PY,
    FACE_NY,
    FACE_PZ,
    FACE_NZ
  } face_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    logic [DIM_W-1:0] box_width;
    logic [DIM_W-1:0] box_height;
    logic [DIM_W-1:0] box_depth;
    logic [SEG_W-1:0] width_seg;
    logic [SEG_W-1:0] height_seg;
    logic [SEG_W-1:0] depth_seg;
  } cfg_t;

  typedef struct packed {
    axis_t u_axis;
    axis_t v_axis;
    axis_t w_axis;
    logic  u_neg;
    logic  v_neg;
    logic  w_neg;
    axis_t seg_u;
    axis_t seg_v;
  } face_desc_t;

  typedef struct packed {
    logic                    pvalid;
    logic                    qvalid;
    logic [IDX_W-1:0]        index;
    logic [STR_W-1:0]        stride;
    logic                    neg_u;
    logic                    neg_v;
    axis_t                   u_axis;
    axis_t                   v_axis;
    axis_t                   w_axis;
    logic signed [POS_W-1:0] dz;
  } side_t;

  function automatic face_desc_t face_desc(face_t f);
    face_desc_t d;
    d = '{AXIS_Z, AXIS_Y, AXIS_X, 1'b1, 1'b1, 1'b0, AXIS_Z, AXIS_Y};
    unique case (f)
      FACE_PX: d = '{AXIS_Z, AXIS_Y, AXIS_X, 1'b1, 1'b1, 1'b0, AXIS_Z, AXIS_Y};
      FACE_NX: d = '{AXIS_Z, AXIS_Y, AXIS_X, 1'b0, 1'b1, 1'b1, AXIS_Z, AXIS_Y};
      FACE_PY: d = '{AXIS_X, AXIS_Z, AXIS_Y, 1'b0, 1'b0, 1'b0, AXIS_X, AXIS_Z};
      FACE_NY: d = '{AXIS_X, AXIS_Z, AXIS_Y, 1'b0, 1'b1, 1'b1, AXIS_X, AXIS_Z};
      FACE_PZ: d = '{AXIS_X, AXIS_Y, AXIS_Z, 1'b0, 1'b1, 1'b0, AXIS_X, AXIS_Y};
      FACE_NZ: d = '{AXIS_X, AXIS_Y, AXIS_Z, 1'b1, 1'b1, 1'b1, AXIS_X, AXIS_Y};
      default: d = '{AXIS_Z, AXIS_Y, AXIS_X, 1'b1, 1'b1, 1'b0, AXIS_Z, AXIS_Y};
    endcase
    return d;
  endfunction

endpackage

>>> sv/bmv_front.sv
// ----------------------------------------------------------------------------
// bmv_front
// Face decode, global index and divider operands for one grid point.
// ----------------------------------------------------------------------------
module bmv_front #(
  parameter int MAX_SEGMENTS = 255
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        en,
  input  bmv_pkg::cfg_t                               cfg,
  input  logic                                        in_vld,
  input  logic [bmv_pkg::FACE_W-1:0]                  in_face,
  input  logic [bmv_pkg::SEG_W-1:0]                   in_col,
  input  logic [bmv_pkg::SEG_W-1:0]                   in_row,
  output logic                                        out_vld,
  output logic [bmv_pkg::NUM_W-1:0]                   out_num [bmv_pkg::LANES],
  output logic [bmv_pkg::SEG_W-1:0]                   out_den [bmv_pkg::LANES],
  output bmv_pkg::side_t                              out_side
);
  import bmv_pkg::*;

  typedef struct packed {
    logic                    pvalid;
    logic                    qvalid;
    face_t                   face;
    logic [SEG_W-1:0]        col;
    logic [SEG_W-1:0]        row;
    logic [SEG_W-1:0]        gx;
    logic [SEG_W-1:0]        gy;
    logic [STR_W-1:0]        stride;
    logic [DIM_W-1:0]        dimx;
    logic [DIM_W-1:0]        dimy;
    logic signed [POS_W-1:0] dz;
    logic                    u_neg;
    logic                    v_neg;
    axis_t                   u_axis;
    axis_t                   v_axis;
    axis_t                   w_axis;
    logic [AREA_W-1:0]       p0;
    logic [AREA_W-1:0]       p1;
    logic [AREA_W-1:0]       p2;
  } s1_t;

  function automatic logic [SEG_W-1:0] seg_clamp(logic [SEG_W-1:0] s);
    logic [SEG_W-1:0] r;
    r = s;
    if (s == '0) r = SEG_W'(1);
    else if (int'(s) > MAX_SEGMENTS) r = SEG_W'(MAX_SEGMENTS);
    return r;
  endfunction

  logic [SEG_W-1:0] gw, gh, gd;
  logic [STR_W-1:0] gw1, gh1, gd1;
  face_desc_t       fd;
  logic             fvalid;
  s1_t              s1_nxt, s1_r;
  logic             s1_vld_r;

  function automatic logic [SEG_W-1:0] pick_seg(axis_t a, logic [SEG_W-1:0] x,
                                                logic [SEG_W-1:0] y, logic [SEG_W-1:0] z);
    logic [SEG_W-1:0] r;
    unique case (a)
      AXIS_X:  r = x;
      AXIS_Y:  r = y;
      default: r = z;
    endcase
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim(axis_t a, cfg_t c);
    logic [DIM_W-1:0] r;
    unique case (a)
      AXIS_X:  r = c.box_width;
      AXIS_Y:  r = c.box_height;
      default: r = c.box_depth;
    endcase
    return r;
  endfunction

  always_comb begin
    gw  = seg_clamp(cfg.width_seg);
    gh  = seg_clamp(cfg.height_seg);
    gd  = seg_clamp(cfg.depth_seg);
    gw1 = STR_W'(gw) + STR_W'(1);
    gh1 = STR_W'(gh) + STR_W'(1);
    gd1 = STR_W'(gd) + STR_W'(1);
    fd  = face_desc(face_t'(in_face));
    fvalid = in_face < FACE_W'(NUM_FACES);

    s1_nxt.face   = face_t'(in_face);
    s1_nxt.col    = in_col;
    s1_nxt.row    = in_row;
    s1_nxt.gx     = pick_seg(fd.seg_u, gw, gh, gd);
    s1_nxt.gy     = pick_seg(fd.seg_v, gw, gh, gd);
    s1_nxt.stride = fvalid ? STR_W'(s1_nxt.gx) + STR_W'(1) : '0;
    s1_nxt.pvalid = fvalid && (in_col <= s1_nxt.gx) && (in_row <= s1_nxt.gy);
    s1_nxt.qvalid = fvalid && (in_col < s1_nxt.gx) && (in_row < s1_nxt.gy);
    s1_nxt.dimx   = pick_dim(fd.seg_u, cfg);
    s1_nxt.dimy   = pick_dim(fd.seg_v, cfg);
    s1_nxt.dz     = fd.w_neg ? -$signed(POS_W'(pick_dim(fd.w_axis, cfg)))
                             : $signed(POS_W'(pick_dim(fd.w_axis, cfg)));
    s1_nxt.u_neg  = fd.u_neg;
    s1_nxt.v_neg  = fd.v_neg;
    s1_nxt.u_axis = fd.u_axis;
    s1_nxt.v_axis = fd.v_axis;
    s1_nxt.w_axis = fd.w_axis;
    s1_nxt.p0     = AREA_W'(gd1) * AREA_W'(gh1);
    s1_nxt.p1     = AREA_W'(gw1) * AREA_W'(gd1);
    s1_nxt.p2     = AREA_W'(gw1) * AREA_W'(gh1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

  logic [IDX_W-1:0] base, row_prod;
  logic [STR_W-1:0] two_c, two_r, gx9, gy9, du, dv;
  logic             lt_u, lt_v;

  always_comb begin
    unique case (s1_r.face)
      FACE_PX: base = '0;
      FACE_NX: base = IDX_W'(s1_r.p0);
      FACE_PY: base = IDX_W'({s1_r.p0, 1'b0});
      FACE_NY: base = IDX_W'({s1_r.p0, 1'b0}) + IDX_W'(s1_r.p1);
      FACE_PZ: base = IDX_W'({s1_r.p0, 1'b0}) + IDX_W'({s1_r.p1, 1'b0});
      FACE_NZ: base = IDX_W'({s1_r.p0, 1'b0}) + IDX_W'({s1_r.p1, 1'b0})
                      + IDX_W'(s1_r.p2);
      default: base = '0;
    endcase
    row_prod = IDX_W'(s1_r.row) * IDX_W'(s1_r.stride);
    two_c = {s1_r.col, 1'b0};
    two_r = {s1_r.row, 1'b0};
    gx9   = STR_W'(s1_r.gx);
    gy9   = STR_W'(s1_r.gy);
    lt_u  = two_c < gx9;
    lt_v  = two_r < gy9;
    du    = lt_u ? gx9 - two_c : two_c - gx9;
    dv    = lt_v ? gy9 - two_r : two_r - gy9;

    out_vld = s1_vld_r;
    out_den[0] = s1_r.gx;
    out_den[1] = s1_r.gy;
    out_den[2] = s1_r.gx;
    out_den[3] = s1_r.gy;
    if (s1_r.pvalid) begin
      out_num[0] = NUM_W'(s1_r.dimx) * NUM_W'(du);
      out_num[1] = NUM_W'(s1_r.dimy) * NUM_W'(dv);
      out_num[2] = NUM_W'(s1_r.col) << UV_SHIFT;
      out_num[3] = (NUM_W'(s1_r.row) << UV_SHIFT) + NUM_W'(s1_r.gy) - NUM_W'(1);
    end else begin
      out_num[0] = '0;
      out_num[1] = '0;
      out_num[2] = '0;
      out_num[3] = '0;
    end

    out_side.pvalid = s1_r.pvalid;
    out_side.qvalid = s1_r.qvalid;
    out_side.index  = s1_r.pvalid ? base + IDX_W'(s1_r.col) + row_prod : '0;
    out_side.stride = s1_r.stride;
    out_side.neg_u  = s1_r.u_neg ^ lt_u;
    out_side.neg_v  = s1_r.v_neg ^ lt_v;
    out_side.u_axis = s1_r.u_axis;
    out_side.v_axis = s1_r.v_axis;
    out_side.w_axis = s1_r.w_axis;
    out_side.dz     = s1_r.dz;
  end

endmodule

>>> sv/bmv_div_pipe.sv
// ----------------------------------------------------------------------------
// bmv_div_pipe
// Restoring divider, one quotient bit per stage, several lanes in step.
// ----------------------------------------------------------------------------
module bmv_div_pipe #(
  parameter int LANES = 4,
  parameter int NW    = 24,
  parameter int QW    = 16,
  parameter int DW    = 8,
  parameter int SW    = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num [LANES],
  input  logic [DW-1:0] in_den [LANES],
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] out_quo [LANES],
  output logic          out_rem_nz [LANES],
  output logic [SW-1:0] out_side
);

  logic          vld_r  [QW];
  logic [DW-1:0] rem_r  [QW][LANES];
  logic [QW-1:0] wrk_r  [QW][LANES];
  logic [DW-1:0] den_r  [QW][LANES];
  logic [SW-1:0] side_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic          vld_in;
    logic [DW-1:0] rem_in [LANES];
    logic [QW-1:0] wrk_in [LANES];
    logic [DW-1:0] den_in [LANES];
    logic [SW-1:0] side_in;
    logic [DW-1:0] rem_nxt [LANES];
    logic [QW-1:0] wrk_nxt [LANES];

    if (s == 0) begin : g_first
      always_comb begin
        vld_in  = in_vld;
        side_in = in_side;
        for (int l = 0; l < LANES; l++) begin
          rem_in[l] = DW'(in_num[l] >> QW);
          wrk_in[l] = in_num[l][QW-1:0];
          den_in[l] = in_den[l];
        end
      end
    end else begin : g_next
      always_comb begin
        vld_in  = vld_r[s-1];
        side_in = side_r[s-1];
        for (int l = 0; l < LANES; l++) begin
          rem_in[l] = rem_r[s-1][l];
          wrk_in[l] = wrk_r[s-1][l];
          den_in[l] = den_r[s-1][l];
        end
      end
    end

    always_comb begin
      logic [DW:0] t;
      for (int l = 0; l < LANES; l++) begin
        t = {rem_in[l], wrk_in[l][QW-1]};
        if (t >= {1'b0, den_in[l]}) begin
          rem_nxt[l] = DW'(t - {1'b0, den_in[l]});
          wrk_nxt[l] = {wrk_in[l][QW-2:0], 1'b1};
        end else begin
          rem_nxt[l] = t[DW-1:0];
          wrk_nxt[l] = {wrk_in[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s] <= side_in;
        for (int l = 0; l < LANES; l++) begin
          rem_r[s][l] <= rem_nxt[l];
          wrk_r[s][l] <= wrk_nxt[l];
          den_r[s][l] <= den_in[l];
        end
      end
    end
  end

  always_comb begin
    out_vld  = vld_r[QW-1];
    out_side = side_r[QW-1];
    for (int l = 0; l < LANES; l++) begin
      out_quo[l]    = wrk_r[QW-1][l];
      out_rem_nz[l] = |rem_r[QW-1][l];
    end
  end

endmodule

>>> sv/box_mesh_vertex_generator.sv
// ----------------------------------------------------------------------------
// box_mesh_vertex_generator
// Position, normal, UV and global index of one grid point on a segmented box.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | face, column, row
//   out_    | output    | out_valid/out_stall| pos, normal, tex, flags, index
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle while out_ is not stalled; the pipeline is a decode stage,
// 16 divider stages and an output register. The divider pipeline sets the depth.
// Synchronous reset clears valid bits and loads the default box registers.
// An out_ stall with out_valid high freezes all stages at once, holding in_stall high.
// ----------------------------------------------------------------------------
module box_mesh_vertex_generator #(
  parameter int MAX_SEGMENTS = 255
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bmv_pkg::FACE_W-1:0]          in_face,
  input  logic [bmv_pkg::SEG_W-1:0]           in_column,
  input  logic [bmv_pkg::SEG_W-1:0]           in_row,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bmv_pkg::POS_W-1:0]    out_pos_x,
  output logic signed [bmv_pkg::POS_W-1:0]    out_pos_y,
  output logic signed [bmv_pkg::POS_W-1:0]    out_pos_z,
  output logic signed [bmv_pkg::NRM_W-1:0]    out_normal_x,
  output logic signed [bmv_pkg::NRM_W-1:0]    out_normal_y,
  output logic signed [bmv_pkg::NRM_W-1:0]    out_normal_z,
  output logic [bmv_pkg::TEX_W-1:0]           out_tex_u,
  output logic [bmv_pkg::TEX_W-1:0]           out_tex_v,
  output logic                                out_point_valid,
  output logic                                out_quad_valid,
  output logic [bmv_pkg::IDX_W-1:0]           out_first_index,
  output logic [bmv_pkg::STR_W-1:0]           out_row_stride,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bmv_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [bmv_pkg::DIM_W-1:0]           cfg_data
);
  import bmv_pkg::*;

  cfg_t  cfg_r;
  logic  en;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.box_width  <= DIM_W'(256);
      cfg_r.box_height <= DIM_W'(256);
      cfg_r.box_depth  <= DIM_W'(256);
      cfg_r.width_seg  <= SEG_W'(1);
      cfg_r.height_seg <= SEG_W'(1);
      cfg_r.depth_seg  <= SEG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BOX_WIDTH:  cfg_r.box_width  <= cfg_data;
        REG_BOX_HEIGHT: cfg_r.box_height <= cfg_data;
        REG_BOX_DEPTH:  cfg_r.box_depth  <= cfg_data;
        REG_WIDTH_SEG:  cfg_r.width_seg  <= cfg_data[SEG_W-1:0];
        REG_HEIGHT_SEG: cfg_r.height_seg <= cfg_data[SEG_W-1:0];
        REG_DEPTH_SEG:  cfg_r.depth_seg  <= cfg_data[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  logic             f_vld;
  logic [NUM_W-1:0] f_num [LANES];
  logic [SEG_W-1:0] f_den [LANES];
  side_t            f_side;

  bmv_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .cfg      (cfg_r),
    .in_vld   (in_valid),
    .in_face  (in_face),
    .in_col   (in_column),
    .in_row   (in_row),
    .out_vld  (f_vld),
    .out_num  (f_num),
    .out_den  (f_den),
    .out_side (f_side)
  );

  logic                       d_vld;
  logic [QUO_W-1:0]           d_quo [LANES];
  logic                       d_rnz [LANES];
  logic [$bits(side_t)-1:0]   d_side_bits;
  side_t                      d_side;

  bmv_div_pipe #(
    .LANES (LANES),
    .NW    (NUM_W),
    .QW    (QUO_W),
    .DW    (SEG_W),
    .SW    ($bits(side_t))
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (f_vld),
    .in_num     (f_num),
    .in_den     (f_den),
    .in_side    (f_side),
    .out_vld    (d_vld),
    .out_quo    (d_quo),
    .out_rem_nz (d_rnz),
    .out_side   (d_side_bits)
  );

  assign d_side = side_t'(d_side_bits);

  logic signed [POS_W-1:0] pu, pv;
  logic signed [POS_W-1:0] pos_nxt [3];
  logic signed [NRM_W-1:0] nrm_nxt [3];
  logic signed [POS_W-1:0] pos_r   [3];
  logic signed [NRM_W-1:0] nrm_r   [3];
  logic [TEX_W-1:0]        tu_r, tv_r;
  logic                    pvalid_r, qvalid_r, out_valid_r;
  logic [IDX_W-1:0]        index_r;
  logic [STR_W-1:0]        stride_r;

  always_comb begin
    logic [POS_W-1:0] mu, mv;
    mu = POS_W'(d_quo[0]);
    mv = POS_W'(d_quo[1]);
    pu = d_side.neg_u ? $signed(POS_W'(0) - mu - POS_W'(d_rnz[0])) : $signed(mu);
    pv = d_side.neg_v ? $signed(POS_W'(0) - mv - POS_W'(d_rnz[1])) : $signed(mv);
    for (int k = 0; k < 3; k++) begin
      pos_nxt[k] = '0;
      nrm_nxt[k] = NRM_ZERO;
      if (d_side.pvalid) begin
        if (d_side.u_axis == axis_t'(k)) pos_nxt[k] = pu;
        if (d_side.v_axis == axis_t'(k)) pos_nxt[k] = pv;
        if (d_side.w_axis == axis_t'(k)) begin
          pos_nxt[k] = d_side.dz;
          nrm_nxt[k] = (d_side.dz > 0) ? NRM_POS : NRM_NEG;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pos_r[k] <= pos_nxt[k];
        nrm_r[k] <= nrm_nxt[k];
      end
      tu_r     <= d_side.pvalid ? d_quo[2] : '0;
      tv_r     <= d_side.pvalid ? UV_ONE - d_quo[3] : '0;
      pvalid_r <= d_side.pvalid;
      qvalid_r <= d_side.qvalid;
      index_r  <= d_side.index;
      stride_r <= d_side.stride;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pos_x       = pos_r[0];
  assign out_pos_y       = pos_r[1];
  assign out_pos_z       = pos_r[2];
  assign out_normal_x    = nrm_r[0];
  assign out_normal_y    = nrm_r[1];
  assign out_normal_z    = nrm_r[2];
  assign out_tex_u       = tu_r;
  assign out_tex_v       = tv_r;
  assign out_point_valid = pvalid_r;
  assign out_quad_valid  = qvalid_r;
  assign out_first_index = index_r;
  assign out_row_stride  = stride_r;

  a_quad_in_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_quad_valid |-> out_point_valid)
    else $error("quad flagged on a point outside the grid");

  a_one_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_valid |->
      $onehot({out_normal_x != 0, out_normal_y != 0, out_normal_z != 0}))
    else $error("normal does not have exactly one axis");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_point_valid |->
      out_pos_x == 0 && out_pos_y == 0 && out_pos_z == 0 &&
      out_tex_u == 0 && out_tex_v == 0 && out_first_index == 0)
    else $error("fields not cleared for a point outside the grid");

  a_uv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tex_u <= UV_ONE && out_tex_v <= UV_ONE)
    else $error("texture coordinate above one");

endmodule

>>> test/box_mesh_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_mesh_checker
// Watches the config, input and result channels of the box mesh vertex
// generator, predicts each vertex from a local register copy and compares
// every result field in order.
// ----------------------------------------------------------------------------
module box_mesh_checker
  import bmv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [FACE_W-1:0]        in_face,
  input  logic [SEG_W-1:0]         in_column,
  input  logic [SEG_W-1:0]         in_row,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [POS_W-1:0]  out_pos_x,
  input  logic signed [POS_W-1:0]  out_pos_y,
  input  logic signed [POS_W-1:0]  out_pos_z,
  input  logic signed [NRM_W-1:0]  out_normal_x,
  input  logic signed [NRM_W-1:0]  out_normal_y,
  input  logic signed [NRM_W-1:0]  out_normal_z,
  input  logic [TEX_W-1:0]         out_tex_u,
  input  logic [TEX_W-1:0]         out_tex_v,
  input  logic                     out_point_valid,
  input  logic                     out_quad_valid,
  input  logic [IDX_W-1:0]         out_first_index,
  input  logic [STR_W-1:0]         out_row_stride,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [DIM_W-1:0]         cfg_data,
  output int                       mismatches,
  output int                       pending
);

  typedef struct packed {
    logic signed [POS_W-1:0] px, py, pz;
    logic signed [NRM_W-1:0] nx, ny, nz;
    logic [TEX_W-1:0]        tu, tv;
    logic                    pv, qv;
    logic [IDX_W-1:0]        idx;
    logic [STR_W-1:0]        stride;
  } vertex_t;

  vertex_t     vertex_q[$];
  logic [15:0] box_regs[6];

  assign pending = vertex_q.size();

  function automatic longint seg_of(int r);
    longint s;
    s = box_regs[r];
    if (s == 0) s = 1;
    if (s > 255) s = 255;
    return s;
  endfunction

  function automatic longint floor_q(longint n, longint d);
    longint q;
    q = n / d;
    if (n % d != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint grid_pos(longint i, longint dim, longint g, bit neg);
    longint n;
    n = 2 * i * dim - dim * g;
    if (neg) n = -n;
    return floor_q(n, g);
  endfunction

  function automatic vertex_t predict_vertex(int f, longint c, longint r);
    vertex_t v;
    int ua[6], va[6], wa[6], un[6], vn[6], wn[6], sx[6], sy[6];
    longint gx, gy, base, dz, p[3];
    v = '0;
    ua = '{2, 2, 0, 0, 0, 0}; va = '{1, 1, 2, 2, 1, 1}; wa = '{0, 0, 1, 1, 2, 2};
    un = '{1, 0, 0, 0, 0, 1}; vn = '{1, 1, 0, 1, 1, 1}; wn = '{0, 1, 0, 1, 0, 1};
    sx = '{REG_DEPTH_SEG, REG_DEPTH_SEG, REG_WIDTH_SEG, REG_WIDTH_SEG, REG_WIDTH_SEG,
           REG_WIDTH_SEG};
    sy = '{REG_HEIGHT_SEG, REG_HEIGHT_SEG, REG_DEPTH_SEG, REG_DEPTH_SEG,
           REG_HEIGHT_SEG, REG_HEIGHT_SEG};
    if (f >= NUM_FACES) return v;
    gx = seg_of(sx[f]);
    gy = seg_of(sy[f]);
    v.stride = STR_W'(gx + 1);
    if (c > gx || r > gy) return v;
    base = 0;
    for (int k = 0; k < f; k++) base += (seg_of(sx[k]) + 1) * (seg_of(sy[k]) + 1);
    dz = wn[f] ? -longint'(box_regs[wa[f]]) : longint'(box_regs[wa[f]]);
    p[ua[f]] = grid_pos(c, box_regs[ua[f]], gx, un[f]);
    p[va[f]] = grid_pos(r, box_regs[va[f]], gy, vn[f]);
    p[wa[f]] = dz;
    v.px = POS_W'(p[0]); v.py = POS_W'(p[1]); v.pz = POS_W'(p[2]);
    case (wa[f])
      0: v.nx = dz > 0 ? NRM_POS : NRM_NEG;
      1: v.ny = dz > 0 ? NRM_POS : NRM_NEG;
      default: v.nz = dz > 0 ? NRM_POS : NRM_NEG;
    endcase
    v.tu = TEX_W'((c * 32768) / gx);
    v.tv = TEX_W'(32768 - (r * 32768 + gy - 1) / gy);
    v.pv = 1'b1;
    v.qv = c < gx && r < gy;
    v.idx = IDX_W'(base + c + r * (gx + 1));
    return v;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin
    vertex_t e, g;
    if (!rst_n) begin
      box_regs = '{256, 256, 256, 1, 1, 1};
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < 6)
        box_regs[cfg_index] = cfg_index < 3 ? cfg_data : {8'h00, cfg_data[7:0]};
      if (in_valid && !in_stall)
        vertex_q.insert(vertex_q.size(), predict_vertex(in_face, in_column, in_row));
      if (out_valid && !out_stall) begin
        g = '{out_pos_x, out_pos_y, out_pos_z, out_normal_x, out_normal_y, out_normal_z,
              out_tex_u, out_tex_v, out_point_valid, out_quad_valid, out_first_index,
              out_row_stride};
        if (vertex_q.size() == 0) begin
          report("unexpected item", 0, 0);
        end else begin
          e = vertex_q.pop_front();
          if (g.px != e.px) report("pos_x", g.px, e.px);
          if (g.py != e.py) report("pos_y", g.py, e.py);
          if (g.pz != e.pz) report("pos_z", g.pz, e.pz);
          if (g.nx != e.nx) report("normal_x", g.nx, e.nx);
          if (g.ny != e.ny) report("normal_y", g.ny, e.ny);
          if (g.nz != e.nz) report("normal_z", g.nz, e.nz);
          if (g.tu != e.tu) report("tex_u", g.tu, e.tu);
          if (g.tv != e.tv) report("tex_v", g.tv, e.tv);
          if (g.pv != e.pv) report("point_valid", g.pv, e.pv);
          if (g.qv != e.qv) report("quad_valid", g.qv, e.qv);
          if (g.idx != e.idx) report("first_index", g.idx, e.idx);
          if (g.stride != e.stride) report("row_stride", g.stride, e.stride);
        end
      end
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives box configurations and grid points into the vertex generator with
// random gaps and stalls; the checker predicts and compares each vertex.
// ----------------------------------------------------------------------------
module testbench;
  import bmv_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  logic [FACE_W-1:0] in_face;
  logic [SEG_W-1:0] in_column, in_row;
  logic signed [POS_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [NRM_W-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic [TEX_W-1:0] out_tex_u, out_tex_v;
  logic out_point_valid, out_quad_valid;
  logic [IDX_W-1:0] out_first_index;
  logic [STR_W-1:0] out_row_stride;
  logic [CIDX_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_data;
  int mismatches, pending, idle_cycles, out_wait;
  logic [7:0] seg_now[3];
  bit stim_done;

  box_mesh_vertex_generator dut (.*);
  box_mesh_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) out_wait <= $urandom_range(0, 9);
  end

  always @(negedge clk) begin
    if (out_wait > 0) begin
      out_stall <= !stim_done;
      out_wait  <= out_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    if (idx >= REG_WIDTH_SEG) seg_now[idx - REG_WIDTH_SEG] = val[7:0];
  endtask

  task automatic set_box(logic [15:0] w, h, d, logic [7:0] sw, sh, sd);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (24) @(negedge clk);
    write_reg(REG_BOX_WIDTH, w);
    write_reg(REG_BOX_HEIGHT, h);
    write_reg(REG_BOX_DEPTH, d);
    write_reg(REG_WIDTH_SEG, sw);
    write_reg(REG_HEIGHT_SEG, sh);
    write_reg(REG_DEPTH_SEG, sd);
  endtask

  task automatic send_point(int f, int c, int r);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1;
    in_face   <= FACE_W'(f);
    in_column <= SEG_W'(c);
    in_row    <= SEG_W'(r);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic random_points(int n);
    int f, lim;
    for (int i = 0; i < n; i++) begin
      f = $urandom_range(0, 7);
      lim = (seg_now[0] == 0) ? 1 : seg_now[0];
      if ($urandom_range(0, 9) == 0) send_point(f, $urandom_range(0, 255), $urandom_range(0, 255));
      else send_point(f, $urandom_range(0, 255 < lim + 1 ? 255 : lim + 1),
                      $urandom_range(0, 255));
    end
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_face = 0; in_column = 0; in_row = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0; out_stall = 0; stim_done = 0;
    idle_cycles = 0; out_wait = 0;
    seg_now = '{1, 1, 1};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    for (int f = 0; f < 8; f++)
      for (int c = 0; c < 3; c++) send_point(f, c, c == 2 ? 0 : 1 - c);
    send_point(FACE_NZ, 255, 255);
    set_box(16'hFFFF, 0, 16'h0001, 255, 0, 255);
    for (int f = 0; f < 6; f++) begin
      send_point(f, 255, 255);
      send_point(f, 0, 254);
    end
    send_point(FACE_PX, 128, 1);
    for (int ph = 0; ph < 8; ph++) begin
      set_box($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
              ph < 4 ? $urandom_range(0, 8) : $urandom_range(0, 255),
              ph < 4 ? $urandom_range(0, 8) : $urandom_range(0, 255),
              ph < 4 ? $urandom_range(0, 8) : $urandom_range(0, 255));
      random_points(50);
      in_valid <= 1'b0;
      while (pending != 0) @(negedge clk);
      random_points(50);
    end
    set_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 255, 255, 255);
    random_points(30);
    in_valid <= 1'b0;
    stim_done = 1;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
